[sv/ord_pkg.sv]
package ord_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_PEEK_FRONT = 3'd4,
		MODE_PEEK_BACK  = 3'd5,
		MODE_READ_INDEX = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_RANGE     = 2'd2,
		ST_OVERWRITE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} cmd_t;

	localparam int MODE_W   = 3;
	localparam int DATA_W   = 16;
	localparam int POS_W    = 4;
	localparam int FILL_W   = 5;
	localparam int STATUS_W = 2;

endpackage

[sv/ord_ram.sv]
module ord_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/ord_ctrl.sv]
module ord_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ord_pkg::cmd_t cmd
);

	ord_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ord_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ord_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ord_pkg::S_EXEC;
				end
			end
			ord_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = ord_pkg::S_FETCH;
			end
			ord_pkg::S_FETCH: begin
				// wait here until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ord_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ord_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ord_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	a_no_result_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an item not yet taken");

	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("captured item not executed next cycle");

	a_exec_then_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == ord_pkg::S_FETCH))
		else $error("execute step not followed by fetch");

endmodule

[sv/ord_dp.sv]
module ord_dp #(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ord_pkg::cmd_t                  cmd,
	input  logic [ord_pkg::MODE_W-1:0]     mode,
	input  logic [ord_pkg::DATA_W-1:0]     data_in,
	input  logic [ord_pkg::POS_W-1:0]      position,
	output logic [ord_pkg::DATA_W-1:0]     data_out,
	output logic [ord_pkg::FILL_W-1:0]     fill_count,
	output logic [ord_pkg::STATUS_W-1:0]   status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam int SW = ((AW > ord_pkg::POS_W) ? AW : ord_pkg::POS_W) + 1;
	localparam int PW = (OW > ord_pkg::POS_W) ? OW : ord_pkg::POS_W;
	localparam int CW = (OW > ord_pkg::FILL_W) ? OW : ord_pkg::FILL_W;
	localparam int DW = (ELEM_WIDTH > ord_pkg::DATA_W) ? ELEM_WIDTH : ord_pkg::DATA_W;

	// captured request
	ord_pkg::mode_t               mode_s1;
	logic [ord_pkg::DATA_W-1:0]   data_s1;
	logic [ord_pkg::POS_W-1:0]    pos_s1;

	// deque state
	logic [AW-1:0] front_q, back_q;
	logic [OW-1:0] occ_q;

	// execute results waiting for the read data
	ord_pkg::status_t st_s2;
	logic             rd_s2;

	logic [ord_pkg::DATA_W-1:0]   data_out_q;
	logic [ord_pkg::FILL_W-1:0]   fill_q;
	ord_pkg::status_t             status_q;

	logic [AW-1:0]   front_d, back_d;
	logic [OW-1:0]   occ_d;
	ord_pkg::status_t st_d;
	logic            we, re;
	logic [AW-1:0]   waddr, raddr;
	logic [ELEM_WIDTH-1:0] wdata, rdata;

	logic            full, empty;
	logic [AW-1:0]   front_nx, front_pv, back_nx, back_pv, idx;
	logic [SW-1:0]   idx_sum, idx_wrap;
	logic            pos_bad;
	logic [DW-1:0]   din_wide, dout_wide;
	logic [CW-1:0]   occ_wide;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1 <= ord_pkg::mode_t'(mode);
			data_s1 <= data_in;
			pos_s1  <= position;
		end
		if (cmd.exec) begin
			st_s2 <= st_d;
			rd_s2 <= re;
		end
		if (cmd.load_out) begin
			dout_wide_hold: begin
				data_out_q <= rd_s2 ? dout_wide[ord_pkg::DATA_W-1:0] : '0;
			end
			fill_q   <= occ_wide[ord_pkg::FILL_W-1:0];
			status_q <= st_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			occ_q   <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			back_q  <= back_d;
			occ_q   <= occ_d;
		end
	end

	assign full  = (occ_q == OW'(DEPTH));
	assign empty = (occ_q == '0);

	// ring steps that also work for depths that are not a power of two
	assign front_nx = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign front_pv = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign back_nx  = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + AW'(1);
	assign back_pv  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);

	// position is below the count here, so one subtract wraps it
	assign idx_sum  = SW'(front_q) + SW'(pos_s1);
	assign idx_wrap = (idx_sum >= SW'(DEPTH)) ? idx_sum - SW'(DEPTH) : idx_sum;
	assign idx      = idx_wrap[AW-1:0];
	assign pos_bad  = (PW'(pos_s1) >= PW'(occ_q));

	assign din_wide  = DW'(data_s1);
	assign wdata     = din_wide[ELEM_WIDTH-1:0];
	assign dout_wide = DW'(rdata);
	assign occ_wide  = CW'(occ_q);

	always_comb begin
		front_d = front_q;
		back_d  = back_q;
		occ_d   = occ_q;
		st_d    = ord_pkg::ST_OK;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = back_q;
		raddr   = front_q;
		if (cmd.exec) begin
			case (mode_s1)
				ord_pkg::MODE_PUSH_BACK: begin
					we     = 1'b1;
					waddr  = back_q;
					back_d = back_nx;
					if (full) begin
						front_d = front_nx;
						st_d    = ord_pkg::ST_OVERWRITE;
					end else begin
						occ_d = occ_q + OW'(1);
					end
				end
				ord_pkg::MODE_PUSH_FRONT: begin
					we      = 1'b1;
					waddr   = front_pv;
					front_d = front_pv;
					if (full) begin
						back_d = front_pv;
						st_d   = ord_pkg::ST_OVERWRITE;
					end else begin
						occ_d = occ_q + OW'(1);
					end
				end
				ord_pkg::MODE_POP_FRONT: begin
					if (empty) begin
						st_d = ord_pkg::ST_EMPTY;
					end else begin
						re      = 1'b1;
						raddr   = front_q;
						front_d = front_nx;
						occ_d   = occ_q - OW'(1);
					end
				end
				ord_pkg::MODE_POP_BACK: begin
					if (empty) begin
						st_d = ord_pkg::ST_EMPTY;
					end else begin
						re     = 1'b1;
						raddr  = back_pv;
						back_d = back_pv;
						occ_d  = occ_q - OW'(1);
					end
				end
				ord_pkg::MODE_PEEK_FRONT: begin
					if (empty) begin
						st_d = ord_pkg::ST_EMPTY;
					end else begin
						re    = 1'b1;
						raddr = front_q;
					end
				end
				ord_pkg::MODE_PEEK_BACK: begin
					if (empty) begin
						st_d = ord_pkg::ST_EMPTY;
					end else begin
						re    = 1'b1;
						raddr = back_pv;
					end
				end
				ord_pkg::MODE_READ_INDEX: begin
					if (pos_bad) begin
						st_d = ord_pkg::ST_RANGE;
					end else begin
						re    = 1'b1;
						raddr = idx;
					end
				end
				default: begin
					// unused mode leaves everything alone
				end
			endcase
		end
	end

	ord_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign data_out   = data_out_q;
	assign fill_count = fill_q;
	assign status     = status_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy above depth");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re))
		else $error("store written and read in the same step");

	a_state_only_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.exec) |-> ($stable(occ_q) && $stable(front_q) && $stable(back_q)))
		else $error("deque state moved outside an execute step");

endmodule

[sv/overwriting_ring_deque.sv]
// an accepted item passes the controller's execute and fetch states and its result is
//   loaded when the output is free; items are taken one at a time, the next only after the
//   capture, store access and result load steps around the registered-read element store
// the next item is accepted while a result waits; a waiting result only stalls the load step
// reset: front and back pointers and the count go to zero, no result pending; the element
//   store is not cleared and needs no clearing pass
module overwriting_ring_deque #(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ord_pkg::MODE_W-1:0]     mode,
	input  logic [ord_pkg::DATA_W-1:0]     data_in,
	input  logic [ord_pkg::POS_W-1:0]      position,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ord_pkg::DATA_W-1:0]     data_out,
	output logic [ord_pkg::FILL_W-1:0]     fill_count,
	output logic [ord_pkg::STATUS_W-1:0]   status
);

	ord_pkg::cmd_t cmd;

	ord_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ord_dp #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.data_in    (data_in),
		.position   (position),
		.data_out   (data_out),
		.fill_count (fill_count),
		.status     (status)
	);

endmodule
